[rtl/ipr_pkg.sv]
// Shared types and constants of the instruction peephole rewriter.
package ipr_pkg;

   // Number of general registers eligible for the zeroing-xor rewrite
   localparam int NUM_GPR = 16;

   // Results one input item can cause: held instruction, new one, end marker
   localparam int MAX_RESULTS = 3;
   localparam int SLOT_IDX_W  = $clog2(MAX_RESULTS + 1);

   // Run queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int KEPT_W = 16;

   // Opcodes
   localparam logic [5:0] OP_MOV    = 6'd0;
   localparam logic [5:0] OP_MOVSS  = 6'd1;
   localparam logic [5:0] OP_MOVSD  = 6'd2;
   localparam logic [5:0] OP_ADD    = 6'd3;
   localparam logic [5:0] OP_SUB    = 6'd4;
   localparam logic [5:0] OP_IMUL   = 6'd5;
   localparam logic [5:0] OP_XOR    = 6'd6;
   localparam logic [5:0] OP_PUSH   = 6'd7;
   localparam logic [5:0] OP_POP    = 6'd8;
   localparam logic [5:0] OP_NOP    = 6'd9;
   localparam logic [5:0] OP_SETCC  = 6'd10;
   localparam logic [5:0] OP_JCC    = 6'd11;
   localparam logic [5:0] OP_CMOVCC = 6'd12;

   // Operand kinds
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_PHYS  = 2'd1;
   localparam logic [1:0] KIND_STACK = 2'd2;
   localparam logic [1:0] KIND_IMM   = 2'd3;

   localparam logic [6:0] WIDTH_32 = 7'd32;
   localparam logic [6:0] WIDTH_64 = 7'd64;
   localparam logic [1:0] COUNT_TWO = 2'd2;

   typedef struct packed {
      logic [5:0]  operation;
      logic [6:0]  width;
      logic [1:0]  num_operands;
      logic [1:0]  dst_kind;
      logic [63:0] dst_value;
      logic [1:0]  src_kind;
      logic [63:0] src_value;
      logic [15:0] other_bits;
   } insn_type;

   // One result: an instruction or the end-of-block marker
   typedef struct packed {
      logic              is_block_end;
      insn_type          insn;
      logic [KEPT_W-1:0] kept_count;
   } slot_type;

   // All results caused by one input item
   typedef struct packed {
      logic [SLOT_IDX_W-1:0]          count;
      slot_type [MAX_RESULTS-1:0]     slot;
   } run_type;

   // Queue status seen by the back part
   typedef struct packed {
      logic    valid;
      run_type head;
   } queue_head_type;

endpackage

[rtl/instruction_peephole_rewriter.sv]
// Top level of the instruction peephole rewriter.
// Instructions of a block enter on the req_ channel (valid/stall) one item at
// a time; kept and rewritten instructions leave on the rsp_ channel in order,
// followed after the block's last instruction by an end marker that carries
// the kept count. rsp_last_of_run flags the last result an input item caused.
// Each instruction is held back until its successor arrives, so its result
// appears only then (or at once for a pass-through or last instruction).
// An accepted run is written into the queue and, once the back part is free,
// loaded into the output register, which drives rsp_valid.
// The front accepts one item per cycle while the two-entry run queue has room;
// the back presents one result per cycle while rsp_stall is low, so the results
// of one item leave in turn (at most three, for the block's last item).
// A stalled rsp_ item holds its payload; the queue lets req_ keep flowing
// until it is full, then req_stall rises.
// Reset empties the queue and the output register, drops the held
// instruction and clears the kept count.
module instruction_peephole_rewriter import ipr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [5:0]  req_operation,
   input  logic [6:0]  req_width,
   input  logic [1:0]  req_num_operands,
   input  logic [1:0]  req_dst_kind,
   input  logic [63:0] req_dst_value,
   input  logic [1:0]  req_src_kind,
   input  logic [63:0] req_src_value,
   input  logic [15:0] req_other_bits,
   input  logic        req_last_in_block,
   input  logic        req_pass_through,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_block_end,
   output logic [5:0]  rsp_out_operation,
   output logic [6:0]  rsp_out_width,
   output logic [1:0]  rsp_out_num_operands,
   output logic [1:0]  rsp_out_dst_kind,
   output logic [63:0] rsp_out_dst_value,
   output logic [1:0]  rsp_out_src_kind,
   output logic [63:0] rsp_out_src_value,
   output logic [15:0] rsp_out_other_bits,
   output logic [15:0] rsp_kept_count,
   output logic        rsp_last_of_run
);

   logic           queue_full;
   logic           push, pop;
   run_type        push_run;
   queue_head_type head;
   slot_type       rsp_slot;

   ipr_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_width         (req_width),
      .req_num_operands  (req_num_operands),
      .req_dst_kind      (req_dst_kind),
      .req_dst_value     (req_dst_value),
      .req_src_kind      (req_src_kind),
      .req_src_value     (req_src_value),
      .req_other_bits    (req_other_bits),
      .req_last_in_block (req_last_in_block),
      .req_pass_through  (req_pass_through),
      .queue_full        (queue_full),
      .push              (push),
      .push_run          (push_run)
   );

   ipr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_run (push_run),
      .pop      (pop),
      .full     (queue_full),
      .head     (head)
   );

   ipr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_slot        (rsp_slot),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // Spread the result onto its field ports
   assign rsp_is_block_end      = rsp_slot.is_block_end;
   assign rsp_out_operation     = rsp_slot.insn.operation;
   assign rsp_out_width         = rsp_slot.insn.width;
   assign rsp_out_num_operands  = rsp_slot.insn.num_operands;
   assign rsp_out_dst_kind      = rsp_slot.insn.dst_kind;
   assign rsp_out_dst_value     = rsp_slot.insn.dst_value;
   assign rsp_out_src_kind      = rsp_slot.insn.src_kind;
   assign rsp_out_src_value     = rsp_slot.insn.src_value;
   assign rsp_out_other_bits    = rsp_slot.insn.other_bits;
   assign rsp_kept_count        = rsp_slot.kept_count;

endmodule

[rtl/ipr_front.sv]
// Front part: holds one instruction for lookahead and builds each item's result run.
module ipr_front import ipr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [5:0]  req_operation,
   input  logic [6:0]  req_width,
   input  logic [1:0]  req_num_operands,
   input  logic [1:0]  req_dst_kind,
   input  logic [63:0] req_dst_value,
   input  logic [1:0]  req_src_kind,
   input  logic [63:0] req_src_value,
   input  logic [15:0] req_other_bits,
   input  logic        req_last_in_block,
   input  logic        req_pass_through,
   input  logic        queue_full,
   output logic        push,
   output run_type     push_run
);

   typedef struct packed {
      logic     keep;
      insn_type insn;
   } judged_type;

   insn_type          held_ff, held_in;
   logic              held_valid_ff, held_valid_in;
   logic [KEPT_W-1:0] kept_ff, kept_in;

   insn_type          x;
   logic              accept;
   logic              pair_push, pair_store;
   judged_type        held_judged, new_judged;
   logic              a_valid, b_valid;
   insn_type          a_insn, b_insn;
   logic [1:0]        n_insn;
   logic [KEPT_W:0]   kept_sum;
   logic [KEPT_W-1:0] kept_new;
   slot_type          end_slot;
   run_type           run;
   logic [SLOT_IDX_W-1:0] n;

   function automatic logic reads_flags(input logic [5:0] op);
      return op == OP_SETCC || op == OP_JCC || op == OP_CMOVCC;
   endfunction

   // Judge one instruction on its own; has_next tells whether a successor follows
   function automatic judged_type judge(input insn_type i, input logic has_next,
                                        input logic [5:0] next_op);
      judged_type r;
      r.keep = 1'b1;
      r.insn = i;
      if ((i.operation == OP_MOV || i.operation == OP_MOVSS || i.operation == OP_MOVSD)
          && i.dst_kind == KIND_PHYS && i.src_kind == KIND_PHYS
          && i.dst_value == i.src_value) begin
         r.keep = 1'b0;
      end else if ((i.operation == OP_ADD || i.operation == OP_SUB)
                   && i.src_kind == KIND_IMM && i.src_value == 64'd0) begin
         r.keep = 1'b0;
      end else if (i.operation == OP_IMUL && i.src_kind == KIND_IMM
                   && i.src_value == 64'd1) begin
         r.keep = 1'b0;
      end else if (i.operation == OP_MOV && i.src_kind == KIND_IMM
                   && i.src_value == 64'd0 && i.dst_kind == KIND_PHYS
                   && i.dst_value < 64'(NUM_GPR)) begin
         if (!(has_next && reads_flags(next_op))) begin
            r.insn.operation = OP_XOR;
            r.insn.src_kind  = KIND_PHYS;
            r.insn.src_value = i.dst_value;
            r.insn.width     = WIDTH_32;
         end
      end else if (i.operation == OP_NOP) begin
         r.keep = 1'b0;
      end
      return r;
   endfunction

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Gather the incoming instruction
   always_comb begin
      x.operation     = req_operation;
      x.width         = req_width;
      x.num_operands  = req_num_operands;
      x.dst_kind      = req_dst_kind;
      x.dst_value     = req_dst_value;
      x.src_kind      = req_src_kind;
      x.src_value     = req_src_value;
      x.other_bits    = req_other_bits;
   end

   // Detect the two pair rewrites
   assign pair_push = held_valid_ff && !req_pass_through
                      && held_ff.operation == OP_PUSH && x.operation == OP_POP
                      && held_ff.dst_kind == KIND_PHYS && x.dst_kind == KIND_PHYS;
   assign pair_store = held_valid_ff && !req_pass_through && !pair_push
                       && held_ff.operation == OP_MOV && held_ff.dst_kind == KIND_STACK
                       && held_ff.src_kind == KIND_PHYS
                       && x.operation == OP_MOV && x.dst_kind == KIND_PHYS
                       && x.src_kind == KIND_STACK && x.src_value == held_ff.dst_value;

   assign held_judged = judge(held_ff, !req_pass_through, x.operation);
   assign new_judged  = judge(x, 1'b0, OP_MOV);

   // Decide what leaves for the held and the incoming instruction
   always_comb begin
      a_valid = 1'b0;
      a_insn  = held_judged.insn;
      b_valid = 1'b0;
      b_insn  = x;
      if (pair_push) begin
         b_valid          = held_ff.dst_value != x.dst_value;
         b_insn.operation = OP_MOV;
         b_insn.num_operands = COUNT_TWO;
         b_insn.src_kind  = KIND_PHYS;
         b_insn.src_value = held_ff.dst_value;
         b_insn.width     = WIDTH_64;
      end else if (pair_store) begin
         a_valid          = 1'b1;
         a_insn           = held_ff;
         b_valid          = x.dst_value != held_ff.src_value;
         b_insn.src_kind  = KIND_PHYS;
         b_insn.src_value = held_ff.src_value;
      end else begin
         a_valid = held_valid_ff && held_judged.keep;
         if (req_pass_through) begin
            b_valid = 1'b1;
         end else if (req_last_in_block) begin
            b_valid = new_judged.keep;
            b_insn  = new_judged.insn;
         end
      end
   end

   // Count kept instructions, saturating
   assign n_insn   = {1'b0, a_valid} + {1'b0, b_valid};
   assign kept_sum = {1'b0, kept_ff} + (KEPT_W + 1)'(n_insn);
   assign kept_new = kept_sum[KEPT_W] ? {KEPT_W{1'b1}} : kept_sum[KEPT_W-1:0];

   always_comb begin
      end_slot              = '0;
      end_slot.is_block_end = 1'b1;
      end_slot.kept_count   = kept_new;
   end

   // Pack the results in order
   always_comb begin
      run = '0;
      n   = '0;
      if (a_valid) begin
         run.slot[n].insn = a_insn;
         n = n + 1'b1;
      end
      if (b_valid) begin
         run.slot[n].insn = b_insn;
         n = n + 1'b1;
      end
      if (req_last_in_block) begin
         run.slot[n] = end_slot;
         n = n + 1'b1;
      end
      run.count = n;
   end

   assign push     = accept && (n != '0);
   assign push_run = run;

   // Advance lookahead and counter
   always_comb begin
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      kept_in       = kept_ff;
      if (accept) begin
         held_valid_in = !(pair_push || pair_store) && !req_pass_through
                         && !req_last_in_block;
         held_in       = x;
         kept_in       = req_last_in_block ? '0 : kept_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         kept_ff       <= '0;
      end else begin
         held_valid_ff <= held_valid_in;
         kept_ff       <= kept_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

[rtl/ipr_queue.sv]
// Short run queue between front and back parts.
module ipr_queue import ipr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  run_type        push_run,
   input  logic           pop,
   output logic           full,
   output queue_head_type head
);

   run_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;

   assign full       = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.head  = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed run
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_run;
      end
   end

endmodule

[rtl/ipr_back.sv]
// Back part: walks each queued run and presents its results one per cycle while rsp_stall is low.
module ipr_back import ipr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output slot_type       rsp_slot,
   output logic           rsp_last_of_run
);

   run_type               cur_ff, cur_in;
   logic                  busy_ff, busy_in;
   logic [SLOT_IDX_W-1:0] idx_ff, idx_in;
   logic                  last_slot, done_now;

   assign last_slot = idx_ff == cur_ff.count - 1'b1;
   assign done_now  = busy_ff && !rsp_stall && last_slot;
   assign pop       = head.valid && (!busy_ff || done_now);

   assign rsp_valid       = busy_ff;
   assign rsp_slot        = cur_ff.slot[idx_ff];
   assign rsp_last_of_run = last_slot;

   // Load a new run or step through the current one
   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (pop) begin
         cur_in  = head.head;
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (done_now) begin
         busy_in = 1'b0;
      end else if (busy_ff && !rsp_stall) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

[bench/ipr_rewrite_checker.sv]
`timescale 1ns / 100ps
// Result checker of the instruction peephole rewriter: predicts and compares every result.
module ipr_rewrite_checker import ipr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [5:0]  req_operation,
   input  logic [6:0]  req_width,
   input  logic [1:0]  req_num_operands,
   input  logic [1:0]  req_dst_kind,
   input  logic [63:0] req_dst_value,
   input  logic [1:0]  req_src_kind,
   input  logic [63:0] req_src_value,
   input  logic [15:0] req_other_bits,
   input  logic        req_last_in_block,
   input  logic        req_pass_through,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_is_block_end,
   input  logic [5:0]  rsp_out_operation,
   input  logic [6:0]  rsp_out_width,
   input  logic [1:0]  rsp_out_num_operands,
   input  logic [1:0]  rsp_out_dst_kind,
   input  logic [63:0] rsp_out_dst_value,
   input  logic [1:0]  rsp_out_src_kind,
   input  logic [63:0] rsp_out_src_value,
   input  logic [15:0] rsp_out_other_bits,
   input  logic [15:0] rsp_kept_count,
   input  logic        rsp_last_of_run,
   input  logic        end_of_test,
   output int          fail_count,
   output int          pending_count,
   output int          results_checked,
   output int          markers_checked
);

   localparam int PRINT_LIMIT = 100;

   typedef struct packed {
      logic        block_end;
      insn_type    insn;
      logic [15:0] kept;
      logic        run_last;
   } rewrite_result_type;

   rewrite_result_type expected_results[$];
   rewrite_result_type step_results[$];
   insn_type      held_insn;
   logic          held_full = 1'b0;
   logic [15:0]   kept_total = '0;
   int            mismatches = 0;
   int            seen = 0;
   int            markers = 0;
   logic          leftovers_checked = 1'b0;

   // Print one line per mismatch, up to a limit, and count them all
   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("[%0t] result %0d: %s", $time, seen, msg);
   endtask

   function automatic logic reads_flags(input logic [5:0] op);
      return op == OP_SETCC || op == OP_JCC || op == OP_CMOVCC;
   endfunction

   // Drop self moves, add/sub of zero, imul by one and nop
   function automatic logic survives(input insn_type x);
      if ((x.operation == OP_MOV || x.operation == OP_MOVSS || x.operation == OP_MOVSD) &&
          x.dst_kind == KIND_PHYS && x.src_kind == KIND_PHYS && x.dst_value == x.src_value)
         return 1'b0;
      if ((x.operation == OP_ADD || x.operation == OP_SUB) &&
          x.src_kind == KIND_IMM && x.src_value == 64'd0)
         return 1'b0;
      if (x.operation == OP_IMUL && x.src_kind == KIND_IMM && x.src_value == 64'd1)
         return 1'b0;
      if (x.operation == OP_NOP)
         return 1'b0;
      return 1'b1;
   endfunction

   // Turn mov gpr,0 into a 32-bit xor unless the successor reads flags
   function automatic insn_type zero_idiom(input insn_type x, input logic has_next,
                                           input logic [5:0] next_op);
      insn_type y;
      y = x;
      if (x.operation == OP_MOV && x.src_kind == KIND_IMM && x.src_value == 64'd0 &&
          x.dst_kind == KIND_PHYS && x.dst_value < 64'(NUM_GPR) &&
          !(has_next && reads_flags(next_op))) begin
         y.operation = OP_XOR;
         y.src_kind = KIND_PHYS;
         y.src_value = x.dst_value;
         y.width = WIDTH_32;
      end
      return y;
   endfunction

   task automatic keep_insn(input insn_type x);
      rewrite_result_type r;
      r = '0;
      r.insn = x;
      step_results.push_back(r);
      if (kept_total != 16'hFFFF)
         kept_total++;
   endtask

   task automatic judge_single(input insn_type x, input logic has_next,
                               input logic [5:0] next_op);
      if (survives(x))
         keep_insn(zero_idiom(x, has_next, next_op));
   endtask

   // Work out the results that one accepted instruction causes
   task automatic rewrite_step(input insn_type x, input logic last, input logic naked);
      insn_type      h;
      insn_type      y;
      logic          paired;
      rewrite_result_type r;
      paired = 1'b0;
      y = x;
      if (held_full) begin
         h = held_insn;
         held_full = 1'b0;
         if (naked) begin
            judge_single(h, 1'b0, OP_MOV);
         end else if (h.operation == OP_PUSH && x.operation == OP_POP &&
                      h.dst_kind == KIND_PHYS && x.dst_kind == KIND_PHYS) begin
            // push rX; pop rY becomes mov rY,rX, or vanishes when X == Y
            if (h.dst_value != x.dst_value) begin
               y.operation = OP_MOV;
               y.num_operands = COUNT_TWO;
               y.src_kind = KIND_PHYS;
               y.src_value = h.dst_value;
               y.width = WIDTH_64;
               keep_insn(y);
            end
            paired = 1'b1;
         end else if (h.operation == OP_MOV && h.dst_kind == KIND_STACK &&
                      h.src_kind == KIND_PHYS && x.operation == OP_MOV &&
                      x.dst_kind == KIND_PHYS && x.src_kind == KIND_STACK &&
                      x.src_value == h.dst_value) begin
            // keep the store, forward the stored register into the load
            keep_insn(h);
            if (x.dst_value != h.src_value) begin
               y.src_kind = KIND_PHYS;
               y.src_value = h.src_value;
               keep_insn(y);
            end
            paired = 1'b1;
         end else begin
            judge_single(h, 1'b1, x.operation);
         end
      end
      if (!paired) begin
         if (naked)
            keep_insn(x);
         else if (last)
            judge_single(x, 1'b0, OP_MOV);
         else begin
            held_insn = x;
            held_full = 1'b1;
         end
      end
      if (last) begin
         r = '0;
         r.block_end = 1'b1;
         r.kept = kept_total;
         step_results.push_back(r);
         kept_total = '0;
         held_full = 1'b0;
      end
      // flag the last result of this item and move the run to the queue
      if (step_results.size() > 0) begin
         r = step_results.pop_back();
         r.run_last = 1'b1;
         step_results.push_back(r);
      end
      while (step_results.size() > 0)
         expected_results.push_back(step_results.pop_front());
   endtask

   task automatic compare_field(input string name, input logic [63:0] got,
                                input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   task automatic check_result();
      rewrite_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("result arrived with nothing expected");
         return;
      end
      want = expected_results.pop_front();
      compare_field("is_block_end", 64'(rsp_is_block_end), 64'(want.block_end));
      compare_field("out_operation", 64'(rsp_out_operation), 64'(want.insn.operation));
      compare_field("out_width", 64'(rsp_out_width), 64'(want.insn.width));
      compare_field("out_num_operands", 64'(rsp_out_num_operands),
                    64'(want.insn.num_operands));
      compare_field("out_dst_kind", 64'(rsp_out_dst_kind), 64'(want.insn.dst_kind));
      compare_field("out_dst_value", rsp_out_dst_value, want.insn.dst_value);
      compare_field("out_src_kind", 64'(rsp_out_src_kind), 64'(want.insn.src_kind));
      compare_field("out_src_value", rsp_out_src_value, want.insn.src_value);
      compare_field("out_other_bits", 64'(rsp_out_other_bits), 64'(want.insn.other_bits));
      compare_field("kept_count", 64'(rsp_kept_count), 64'(want.kept));
      compare_field("last_of_run", 64'(rsp_last_of_run), 64'(want.run_last));
   endtask

   // Check results before predicting, so a result never meets its own item
   always @(posedge clock) begin
      if (reset) begin
         held_full = 1'b0;
         kept_total = '0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen++;
            if (rsp_is_block_end === 1'b1)
               markers++;
            check_result();
         end
         if (req_valid && !req_stall)
            rewrite_step('{req_operation, req_width, req_num_operands, req_dst_kind,
                           req_dst_value, req_src_kind, req_src_value, req_other_bits},
                         req_last_in_block, req_pass_through);
         if (end_of_test && !leftovers_checked) begin
            leftovers_checked = 1'b1;
            if (expected_results.size() != 0)
               report_mismatch($sformatf("%0d expected results never arrived",
                                         expected_results.size()));
         end
      end
      fail_count <= mismatches;
      pending_count <= expected_results.size();
      results_checked <= seen;
      markers_checked <= markers;
   end

endmodule

[bench/tb_instruction_peephole_rewriter.sv]
`timescale 1ns / 100ps
// Testbench top of the instruction peephole rewriter: stimulus, idling and verdict.
module tb_instruction_peephole_rewriter import ipr_pkg::*;;

   localparam int TIMEOUT_NS  = 5_000_000;
   localparam int DRAIN_LIMIT = 20_000;
   localparam int TAIL_CYCLES = 20;

   typedef struct {
      insn_type insn;
      logic     last;
      logic     naked;
   } stim_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [5:0]  req_operation = '0;
   logic [6:0]  req_width = '0;
   logic [1:0]  req_num_operands = '0;
   logic [1:0]  req_dst_kind = '0;
   logic [63:0] req_dst_value = '0;
   logic [1:0]  req_src_kind = '0;
   logic [63:0] req_src_value = '0;
   logic [15:0] req_other_bits = '0;
   logic        req_last_in_block = 1'b0;
   logic        req_pass_through = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_is_block_end;
   logic [5:0]  rsp_out_operation;
   logic [6:0]  rsp_out_width;
   logic [1:0]  rsp_out_num_operands;
   logic [1:0]  rsp_out_dst_kind;
   logic [63:0] rsp_out_dst_value;
   logic [1:0]  rsp_out_src_kind;
   logic [63:0] rsp_out_src_value;
   logic [15:0] rsp_out_other_bits;
   logic [15:0] rsp_kept_count;
   logic        rsp_last_of_run;
   logic        end_of_test = 1'b0;
   int          fail_count;
   int          pending_count;
   int          results_checked;
   int          markers_checked;

   stim_item_type stim_q[$];
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   logic        naked_block = 1'b0;
   int          items_sent = 0;
   int          blocks_sent = 0;
   int          naked_sent = 0;

   instruction_peephole_rewriter uut (.*);

   ipr_rewrite_checker checker_i (.*);

   always #5 clock = ~clock;

   // Stall the result side at the current rate
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   initial begin
      #(TIMEOUT_NS);
      $display("instruction_peephole_rewriter regression: fail");
      $finish;
   end

   function automatic logic [63:0] pick_reg();
      if ($urandom_range(9) == 0)
         return {$urandom, $urandom};
      return 64'($urandom_range(NUM_GPR + 3));
   endfunction

   function automatic logic [63:0] pick_slot();
      logic [63:0] off;
      off = 64'd8 * $urandom_range(1, 8);
      if ($urandom_range(1) == 0)
         off = -off;
      return off;
   endfunction

   function automatic logic [6:0] pick_width();
      case ($urandom_range(3))
         0: return 7'd8;
         1: return 7'd16;
         2: return WIDTH_32;
         default: return WIDTH_64;
      endcase
   endfunction

   // Mostly the usual kind, now and then any kind
   function automatic logic [1:0] pick_kind(input logic [1:0] usual);
      if ($urandom_range(6) == 0)
         return 2'($urandom_range(3));
      return usual;
   endfunction

   task automatic add_item(input logic [5:0] op, input logic [6:0] wid, input logic [1:0] cnt,
                           input logic [1:0] dk, input logic [63:0] dv, input logic [1:0] sk,
                           input logic [63:0] sv, input logic [15:0] oth, input logic last,
                           input logic naked);
      stim_item_type s;
      s.insn = '{op, wid, cnt, dk, dv, sk, sv, oth};
      s.last = last;
      s.naked = naked;
      stim_q.push_back(s);
   endtask

   // Queue one instruction of a random block, pass-through now and then
   task automatic queue_insn(input logic [5:0] op, input logic [1:0] dk, input logic [63:0] dv,
                             input logic [1:0] sk, input logic [63:0] sv);
      add_item(op, pick_width(), 2'($urandom_range(3)), dk, dv, sk, sv,
               16'($urandom_range(65535)), 1'b0, naked_block || ($urandom_range(24) == 0));
   endtask

   task automatic queue_noise();
      add_item(6'($urandom_range(63)), 7'($urandom_range(127)), 2'($urandom_range(3)),
               2'($urandom_range(3)), {$urandom, $urandom}, 2'($urandom_range(3)),
               {$urandom, $urandom}, 16'($urandom_range(65535)), 1'b0,
               naked_block || ($urandom_range(24) == 0));
   endtask

   // Append one well-formed rewrite opportunity, or noise
   task automatic add_pattern();
      logic [63:0] ra;
      logic [63:0] rb;
      logic [63:0] slot;
      ra = pick_reg();
      rb = ($urandom_range(1) == 0) ? ra : pick_reg();
      slot = pick_slot();
      case ($urandom_range(9))
         0: begin
            queue_insn(OP_PUSH, pick_kind(KIND_PHYS), ra, pick_kind(KIND_NONE), '0);
            queue_insn(OP_POP, pick_kind(KIND_PHYS), rb, pick_kind(KIND_NONE), '0);
         end
         1: begin
            queue_insn(OP_MOV, pick_kind(KIND_STACK), slot, pick_kind(KIND_PHYS), ra);
            queue_insn(OP_MOV, pick_kind(KIND_PHYS), rb, pick_kind(KIND_STACK),
                       ($urandom_range(3) == 0) ? slot + 64'd8 : slot);
         end
         2: queue_insn(6'(OP_MOV + $urandom_range(2)), pick_kind(KIND_PHYS), ra,
                       pick_kind(KIND_PHYS), rb);
         3: queue_insn(($urandom_range(1) == 0) ? OP_ADD : OP_SUB, pick_kind(KIND_PHYS), ra,
                       pick_kind(KIND_IMM), ($urandom_range(1) == 0) ? 64'd0 : pick_reg());
         4: queue_insn(OP_IMUL, pick_kind(KIND_PHYS), ra, pick_kind(KIND_IMM),
                       ($urandom_range(1) == 0) ? 64'd1 : 64'($urandom_range(2)));
         5: queue_insn(OP_NOP, pick_kind(KIND_NONE), '0, pick_kind(KIND_NONE), '0);
         6: begin
            queue_insn(OP_MOV, pick_kind(KIND_PHYS), ra, pick_kind(KIND_IMM),
                       ($urandom_range(3) == 0) ? 64'd1 : 64'd0);
            if ($urandom_range(1) == 0)
               queue_insn(6'(OP_SETCC + $urandom_range(2)), pick_kind(KIND_PHYS), rb,
                          pick_kind(KIND_PHYS), ra);
         end
         7: queue_insn(6'(OP_SETCC + $urandom_range(2)), pick_kind(KIND_PHYS), ra,
                       pick_kind(KIND_PHYS), rb);
         8: queue_noise();
         default: queue_insn(6'($urandom_range(63)), 2'($urandom_range(3)), ra,
                             2'($urandom_range(3)), rb);
      endcase
   endtask

   // Build one block, mostly short, closed by its last instruction
   task automatic build_block();
      int       len;
      int       start;
      stim_item_type s;
      naked_block = ($urandom_range(9) == 0);
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      start = stim_q.size();
      while (stim_q.size() - start < len)
         add_pattern();
      s = stim_q.pop_back();
      s.last = 1'b1;
      stim_q.push_back(s);
   endtask

   task automatic build_random(input int count);
      while (stim_q.size() < count)
         build_block();
   endtask

   task automatic build_directed();
      // self moves, dropped arithmetic and nop
      add_item(OP_MOV, WIDTH_64, 2'd2, KIND_PHYS, 64'd3, KIND_PHYS, 64'd3, 16'h0000,
               1'b0, 1'b0);
      add_item(OP_MOVSS, WIDTH_32, 2'd2, KIND_PHYS, 64'd5, KIND_PHYS, 64'd5, 16'h0001,
               1'b0, 1'b0);
      add_item(OP_MOVSD, WIDTH_64, 2'd2, KIND_PHYS, 64'd7, KIND_PHYS, 64'd7, 16'h0002,
               1'b0, 1'b0);
      add_item(OP_ADD, WIDTH_32, 2'd2, KIND_PHYS, 64'd1, KIND_IMM, 64'd0, 16'h0003,
               1'b0, 1'b0);
      add_item(OP_SUB, WIDTH_64, 2'd2, KIND_PHYS, 64'd2, KIND_IMM, 64'd0, 16'h0004,
               1'b0, 1'b0);
      add_item(OP_IMUL, WIDTH_32, 2'd2, KIND_PHYS, 64'd4, KIND_IMM, 64'd1, 16'h0005,
               1'b0, 1'b0);
      add_item(OP_NOP, 7'd0, 2'd0, KIND_NONE, 64'd0, KIND_NONE, 64'd0, 16'h0006,
               1'b0, 1'b0);
      // zeroing mov: kept before setcc, xor before anything else
      add_item(OP_MOV, WIDTH_64, 2'd2, KIND_PHYS, 64'd0, KIND_IMM, 64'd0, 16'h0007,
               1'b0, 1'b0);
      add_item(OP_SETCC, 7'd8, 2'd1, KIND_PHYS, 64'd0, KIND_NONE, 64'd0, 16'h0008,
               1'b0, 1'b0);
      add_item(OP_MOV, WIDTH_64, 2'd2, KIND_PHYS, 64'd15, KIND_IMM, 64'd0, 16'h0009,
               1'b0, 1'b0);
      add_item(OP_XOR, 7'd127, 2'd3, KIND_PHYS, 64'h7FFF_FFFF_FFFF_FFFF, KIND_IMM,
               64'h8000_0000_0000_0000, 16'hFFFF, 1'b0, 1'b0);
      // push/pop of the same register, then of two registers
      add_item(OP_PUSH, WIDTH_64, 2'd1, KIND_PHYS, 64'd1, KIND_NONE, 64'd0, 16'h000A,
               1'b0, 1'b0);
      add_item(OP_POP, WIDTH_64, 2'd1, KIND_PHYS, 64'd1, KIND_NONE, 64'd0, 16'h000B,
               1'b0, 1'b0);
      add_item(OP_PUSH, WIDTH_64, 2'd1, KIND_PHYS, 64'd2, KIND_NONE, 64'd0, 16'h000C,
               1'b0, 1'b0);
      add_item(OP_POP, WIDTH_64, 2'd1, KIND_PHYS, 64'd9, KIND_NONE, 64'd0, 16'h000D,
               1'b0, 1'b0);
      // store then load of one stack slot, same and other register
      add_item(OP_MOV, WIDTH_64, 2'd2, KIND_STACK, -64'sd8, KIND_PHYS, 64'd3, 16'h000E,
               1'b0, 1'b0);
      add_item(OP_MOV, WIDTH_64, 2'd2, KIND_PHYS, 64'd3, KIND_STACK, -64'sd8, 16'h000F,
               1'b0, 1'b0);
      add_item(OP_MOV, WIDTH_64, 2'd2, KIND_STACK, 64'd16, KIND_PHYS, 64'd4, 16'h0010,
               1'b0, 1'b0);
      add_item(OP_MOV, WIDTH_64, 2'd2, KIND_PHYS, 64'd6, KIND_STACK, 64'd16, 16'h0011,
               1'b0, 1'b0);
      // zeroing mov before cmovcc, and into a register past the general ones
      add_item(OP_MOV, WIDTH_64, 2'd2, KIND_PHYS, 64'd1, KIND_IMM, 64'd0, 16'h0012,
               1'b0, 1'b0);
      add_item(OP_CMOVCC, WIDTH_64, 2'd2, KIND_PHYS, 64'd1, KIND_PHYS, 64'd2, 16'h0013,
               1'b0, 1'b0);
      add_item(OP_MOV, WIDTH_64, 2'd2, KIND_PHYS, 64'd16, KIND_IMM, 64'd0, 16'h0014,
               1'b0, 1'b0);
      add_item(OP_JCC, 7'd0, 2'd1, KIND_IMM, '1, KIND_NONE, 64'd0, 16'h0015, 1'b0, 1'b0);
      // last instruction is judged alone: zeroing mov becomes xor
      add_item(OP_MOV, WIDTH_64, 2'd2, KIND_PHYS, 64'd2, KIND_IMM, 64'd0, 16'h0016,
               1'b1, 1'b0);
      // held instruction judged alone before a pass-through one that ends the block
      add_item(OP_IMUL, WIDTH_32, 2'd2, KIND_PHYS, 64'd1, KIND_IMM, 64'd1, 16'h0017,
               1'b0, 1'b0);
      add_item(6'd63, 7'd0, 2'd0, KIND_IMM, 64'h8000_0000_0000_0000, KIND_IMM,
               64'h7FFF_FFFF_FFFF_FFFF, 16'h0000, 1'b1, 1'b1);
   endtask

   // Drive one item from a falling edge and hold it until accepted
   task automatic send_item(input stim_item_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= s.insn.operation;
      req_width <= s.insn.width;
      req_num_operands <= s.insn.num_operands;
      req_dst_kind <= s.insn.dst_kind;
      req_dst_value <= s.insn.dst_value;
      req_src_kind <= s.insn.src_kind;
      req_src_value <= s.insn.src_value;
      req_other_bits <= s.insn.other_bits;
      req_last_in_block <= s.last;
      req_pass_through <= s.naked;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
      if (s.last)
         blocks_sent++;
      if (s.naked)
         naked_sent++;
      @(negedge clock);
   endtask

   task automatic drain_stim(input int idle_pct, input int stall_rate);
      send_idle_pct = idle_pct;
      stall_pct = stall_rate;
      while (stim_q.size() > 0)
         send_item(stim_q.pop_front());
   endtask

   initial begin
      int waited;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      build_directed();
      drain_stim(0, 0);
      // random blocks under each idling pattern
      build_random(75);
      drain_stim(0, 0);
      build_random(75);
      drain_stim(67, 0);
      build_random(75);
      drain_stim(0, 67);
      build_random(75);
      drain_stim(33, 33);
      req_valid <= 1'b0;
      stall_pct = 0;
      // wait for outstanding results, then a short tail
      waited = 0;
      while (pending_count != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);
      end_of_test <= 1'b1;
      repeat (3) @(posedge clock);
      $display("sent %0d instructions in %0d blocks, %0d of them pass-through",
               items_sent, blocks_sent, naked_sent);
      $display("checked %0d results including %0d end-of-block markers, %0d mismatches",
               results_checked, markers_checked, fail_count);
      if (fail_count == 0)
         $display("instruction_peephole_rewriter regression: pass");
      else
         $display("instruction_peephole_rewriter regression: fail");
      $finish;
   end

endmodule

[filelist.f]
rtl/ipr_pkg.sv
rtl/ipr_front.sv
rtl/ipr_queue.sv
rtl/ipr_back.sv
rtl/instruction_peephole_rewriter.sv
bench/ipr_rewrite_checker.sv
bench/tb_instruction_peephole_rewriter.sv
